@@ sv/yee_grid_field_interpolator_top_defines.svh @@
// Shared assertion macros
`ifndef YEE_GRID_FIELD_INTERPOLATOR_TOP_DEFINES_SVH
`define YEE_GRID_FIELD_INTERPOLATOR_TOP_DEFINES_SVH

// same-cycle implication
`define YGI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define YGI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/yee_gfi_pkg.sv @@
`default_nettype none
package yee_gfi_pkg;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_E     = 2'd1;
	localparam logic [1:0] MODE_B     = 2'd2;

	localparam logic [1:0] CFG_INV_X = 2'd0;
	localparam logic [1:0] CFG_INV_Y = 2'd1;
	localparam logic [1:0] CFG_INV_Z = 2'd2;

	localparam logic [1:0] COMP_NONE = 2'd3;

	localparam logic [3:0] MUL_LAST   = 4'd3;
	localparam logic [3:0] READ_LAST  = 4'd8;
	localparam logic [3:0] LERP_LAST  = 4'd6;
	localparam logic [2:0] STEP_Y0    = 3'd4;
	localparam logic [2:0] STEP_X     = 3'd6;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL,
		S_CHK,
		S_READ,
		S_LERP,
		S_FIN
	} state_t;

	typedef struct packed {
		logic       clear;
		logic       wr;
		logic       load;
		logic       mul;
		logic [1:0] mul_axis;
		logic       der;
		logic [1:0] der_axis;
		logic       rd;
		logic [2:0] corner;
		logic       shift;
		logic       lerp;
		logic [2:0] step;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic outside;
	} sts_t;

endpackage
`default_nettype wire

@@ sv/yee_grid_field_interpolator_top.sv @@
// channel | dir | signals
// in      | in  | in_valid/in_ready, mode, pos_*, node_*, component, which_field, node_value
// out     | out | out_valid/out_ready, field_x/y/z, out_of_grid
// cfg     | in  | cfg_valid/cfg_ready, cfg_index, cfg_data
// A write request is taken while the controller stays idle; a query passes the shared
// 32x32 position multiplier, eight corner reads of the three component banks and
// the lerp chain per lane, plus handoff. After reset a clearing pass writes zeros to
// all 2*GRID_X*GRID_Y*GRID_Z words of each bank; no request is taken meanwhile.
// A held result stalls only the end of the next query.
`default_nettype none
module yee_grid_field_interpolator_top
	import yee_gfi_pkg::*;
#(
	parameter int GRID_X = 32,
	parameter int GRID_Y = 32,
	parameter int GRID_Z = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         mode,
	input  wire logic [31:0]        pos_x,
	input  wire logic [31:0]        pos_y,
	input  wire logic [31:0]        pos_z,
	input  wire logic [4:0]         node_x,
	input  wire logic [4:0]         node_y,
	input  wire logic [4:0]         node_z,
	input  wire logic [1:0]         component,
	input  wire logic               which_field,
	input  wire logic signed [31:0] node_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      field_x,
	output logic signed [31:0]      field_y,
	output logic signed [31:0]      field_z,
	output logic                    out_of_grid,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	yee_gfi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	yee_gfi_dp #(
		.GRID_X (GRID_X),
		.GRID_Y (GRID_Y),
		.GRID_Z (GRID_Z)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mode        (mode),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.node_x      (node_x),
		.node_y      (node_y),
		.node_z      (node_z),
		.component   (component),
		.which_field (which_field),
		.node_value  (node_value),
		.field_x     (field_x),
		.field_y     (field_y),
		.field_z     (field_z),
		.out_of_grid (out_of_grid)
	);

endmodule
`default_nettype wire

@@ sv/yee_gfi_dp.sv @@
`default_nettype none
module yee_gfi_dp
	import yee_gfi_pkg::*;
#(
	parameter int GRID_X = 32,
	parameter int GRID_Y = 32,
	parameter int GRID_Z = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output sts_t                    sts,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic [1:0]         mode,
	input  wire logic [31:0]        pos_x,
	input  wire logic [31:0]        pos_y,
	input  wire logic [31:0]        pos_z,
	input  wire logic [4:0]         node_x,
	input  wire logic [4:0]         node_y,
	input  wire logic [4:0]         node_z,
	input  wire logic [1:0]         component,
	input  wire logic               which_field,
	input  wire logic signed [31:0] node_value,
	output logic signed [31:0]      field_x,
	output logic signed [31:0]      field_y,
	output logic signed [31:0]      field_z,
	output logic                    out_of_grid
);

	localparam longint DEPTH = 2 * longint'(GRID_X) * longint'(GRID_Y) * longint'(GRID_Z);
	localparam int AW = $clog2(DEPTH);
	localparam int GXY = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
	localparam int GM = (GXY > GRID_Z) ? GXY : GRID_Z;
	localparam int NW = $clog2(GM + 1);
	localparam logic [32:0] LIM [3] = '{33'(GRID_X), 33'(GRID_Y), 33'(GRID_Z)};

	function automatic logic [AW-1:0] addr_of(input logic f, input logic [NW-1:0] x,
		input logic [NW-1:0] y, input logic [NW-1:0] z);
		logic [63:0] t;
		t = ((64'(f) * 64'(GRID_X) + 64'(x)) * 64'(GRID_Y) + 64'(y)) * 64'(GRID_Z) + 64'(z);
		return t[AW-1:0];
	endfunction

	function automatic logic signed [31:0] lerp(input logic signed [31:0] a,
		input logic signed [31:0] b, input logic [15:0] w);
		logic signed [32:0] d;
		logic signed [49:0] p;
		logic signed [34:0] s;
		d = $signed({b[31], b}) - $signed({a[31], a});
		p = d * $signed({1'b0, w});
		p = p + 50'sd32768;
		s = $signed({p[49], p[49:16]}) + $signed({{3{a[31]}}, a});
		if (s > 35'sd2147483647)
			return 32'sh7fffffff;
		else if (s < -35'sd2147483648)
			return 32'sh80000000;
		else
			return s[31:0];
	endfunction

	logic [31:0]       inv_q [3];
	logic [31:0]       pos_q [3];
	logic              f_q;
	logic [63:0]       prod_q;
	logic [NW-1:0]     ni_q [3];
	logic [NW-1:0]     nh_q [3];
	logic [15:0]       wi_q [3];
	logic [15:0]       wh_q [3];
	logic              outside_q;
	logic [AW-1:0]     clr_q;
	logic signed [31:0] rd_s1 [3];
	logic signed [31:0] r_q [3][8];

	logic [NW-1:0]     nl [3][3];
	logic [15:0]       wl [3][3];
	logic [AW-1:0]     ra [3];
	logic [AW-1:0]     wa;
	logic [31:0]       wd;
	logic              wr_ok;
	logic [2:0]        we;
	logic [47:0]       s_d;
	logic [47:0]       h_d;
	logic [32:0]       fl_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q[0] <= 32'd65536;
			inv_q[1] <= 32'd65536;
			inv_q[2] <= 32'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INV_X: inv_q[0] <= cfg_data;
				CFG_INV_Y: inv_q[1] <= cfg_data;
				CFG_INV_Z: inv_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.clear)
			clr_q <= clr_q + 1'b1;
	end
	assign sts.clr_last = (clr_q == AW'(DEPTH - 1));

	assign s_d  = prod_q[63:16];
	assign h_d  = s_d + 48'h8000;
	assign fl_d = {1'b0, s_d[47:16]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q[0]  <= pos_x;
			pos_q[1]  <= pos_y;
			pos_q[2]  <= pos_z;
			f_q       <= (mode == MODE_B);
			outside_q <= 1'b0;
		end
		if (cmd.mul)
			prod_q <= 64'(pos_q[cmd.mul_axis]) * 64'(inv_q[cmd.mul_axis]);
		if (cmd.der) begin
			ni_q[cmd.der_axis] <= fl_d[NW-1:0] + 1'b1;
			wi_q[cmd.der_axis] <= s_d[15:0];
			nh_q[cmd.der_axis] <= h_d[16+NW-1:16];
			wh_q[cmd.der_axis] <= h_d[15:0];
			if (fl_d + 33'd2 >= LIM[cmd.der_axis])
				outside_q <= 1'b1;
		end
	end
	assign sts.outside = outside_q;

	// E component c is half-shifted on axis c only, B on all others
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int a = 0; a < 3; a++) begin
				if (f_q ? (a != c) : (a == c)) begin
					nl[c][a] = nh_q[a];
					wl[c][a] = wh_q[a];
				end else begin
					nl[c][a] = ni_q[a];
					wl[c][a] = wi_q[a];
				end
			end
			ra[c] = addr_of(f_q, nl[c][0] + NW'(cmd.corner[2]),
				nl[c][1] + NW'(cmd.corner[1]), nl[c][2] + NW'(cmd.corner[0]));
		end
	end

	assign wr_ok = (component != COMP_NONE) && (11'(node_x) < 11'(GRID_X))
		&& (11'(node_y) < 11'(GRID_Y)) && (11'(node_z) < 11'(GRID_Z));
	assign wa = cmd.clear ? clr_q
		: addr_of(which_field, NW'(node_x), NW'(node_y), NW'(node_z));
	assign wd = cmd.clear ? 32'd0 : node_value;

	for (genvar c = 0; c < 3; c++) begin : g_bank
		logic [31:0] mem [DEPTH];

		assign we[c] = cmd.clear || (cmd.wr && wr_ok && (component == 2'(c)));

		always_ff @(posedge clk) begin
			if (we[c])
				mem[wa] <= wd;
			if (cmd.rd)
				rd_s1[c] <= mem[ra[c]];
		end

		logic [15:0]        w_sel;
		logic signed [31:0] res;

		always_comb begin
			if (cmd.step < STEP_Y0)
				w_sel = wl[c][2];
			else if (cmd.step < STEP_X)
				w_sel = wl[c][1];
			else
				w_sel = wl[c][0];
			res = lerp(r_q[c][0], r_q[c][1], w_sel);
		end

		// queue: corners shift in at the tail; each step folds the head pair
		always_ff @(posedge clk) begin
			if (cmd.shift) begin
				for (int i = 0; i < 7; i++)
					r_q[c][i] <= r_q[c][i+1];
				r_q[c][7] <= rd_s1[c];
			end else if (cmd.lerp) begin
				for (int i = 0; i < 8; i++) begin
					if (i == 6 - int'(cmd.step))
						r_q[c][i] <= res;
					else if (i < 6)
						r_q[c][i] <= r_q[c][i+2];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			field_x     <= outside_q ? 32'sd0 : r_q[0][0];
			field_y     <= outside_q ? 32'sd0 : r_q[1][0];
			field_z     <= outside_q ? 32'sd0 : r_q[2][0];
			out_of_grid <= outside_q;
		end
	end

endmodule
`default_nettype wire

@@ sv/yee_gfi_ctrl.sv @@
`default_nettype none
module yee_gfi_ctrl
	import yee_gfi_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] mode,
	output logic            out_valid,
	input  wire logic       out_ready,
	output cmd_t            cmd,
	input  wire sts_t       sts
);

	state_t     state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q + 1'b1;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				cnt_d    = '0;
				if (in_valid) begin
					if (mode == MODE_WRITE)
						cmd.wr = 1'b1;
					else if (mode == MODE_E || mode == MODE_B) begin
						cmd.load = 1'b1;
						state_d  = S_MUL;
					end
				end
			end
			S_MUL: begin
				cmd.mul      = (cnt_q < MUL_LAST);
				cmd.mul_axis = cnt_q[1:0];
				cmd.der      = (cnt_q != 4'd0);
				cmd.der_axis = cnt_q[1:0] - 2'd1;
				if (cnt_q == MUL_LAST)
					state_d = S_CHK;
			end
			S_CHK: begin
				cnt_d   = '0;
				state_d = sts.outside ? S_FIN : S_READ;
			end
			S_READ: begin
				cmd.rd     = (cnt_q < READ_LAST);
				cmd.corner = cnt_q[2:0];
				cmd.shift  = (cnt_q != 4'd0);
				if (cnt_q == READ_LAST) begin
					cnt_d   = '0;
					state_d = S_LERP;
				end
			end
			S_LERP: begin
				cmd.lerp = 1'b1;
				cmd.step = cnt_q[2:0];
				if (cnt_q == LERP_LAST)
					state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	`include "yee_grid_field_interpolator_top_defines.svh"

	`YGI_ASSERT_NEXT(a_query_starts, clk, arst_n, in_valid && in_ready && (mode == MODE_E || mode == MODE_B), state_q == S_MUL, "query did not start")
	`YGI_ASSERT_NEXT(a_lerp_ends, clk, arst_n, state_q == S_LERP && cnt_q == LERP_LAST, state_q == S_FIN, "lerp sequence overran")
	`YGI_ASSERT_NEXT(a_fin_holds, clk, arst_n, state_q == S_FIN && out_valid_q && !out_ready, state_q == S_FIN && out_valid_q, "result overwritten")
	`YGI_ASSERT_NOW(a_no_clear_accept, clk, arst_n, cmd.clear, !in_ready, "request taken during clear")

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import yee_gfi_pkg::*;

	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam int GRID = 32;
	localparam int STORE_DEPTH = 2 * 3 * GRID * GRID * GRID;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic signed [31:0] fz;
		logic               oog;
	} field_sample_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         mode;
	logic [31:0]        pos_x, pos_y, pos_z;
	logic [4:0]         node_x, node_y, node_z;
	logic [1:0]         component;
	logic               which_field;
	logic signed [31:0] node_value;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] field_x, field_y, field_z;
	logic               out_of_grid;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;

	logic [31:0]   node_mem [0:STORE_DEPTH-1];
	logic [31:0]   inv_cell [0:2];
	field_sample_t pending_fields[$];
	int            mismatches;
	int            send_idle_pct;
	int            recv_stall_pct;

	yee_grid_field_interpolator_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.node_x(node_x), .node_y(node_y), .node_z(node_z),
		.component(component), .which_field(which_field), .node_value(node_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.field_x(field_x), .field_y(field_y), .field_z(field_z),
		.out_of_grid(out_of_grid),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int node_addr(int f, int c, int x, int y, int z);
		return (((f * 3 + c) * GRID + x) * GRID + y) * GRID + z;
	endfunction

	function automatic longint node_read(int f, int c, int x, int y, int z);
		return longint'($signed(node_mem[node_addr(f, c, x, y, z)]));
	endfunction

	function automatic longint blend(longint a, longint b, longint w1);
		longint acc;
		acc = a * (65536 - w1) + b * w1 + 32768;
		return acc >>> 16;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic field_sample_t gather_field(int f, logic [31:0] px, logic [31:0] py,
			logic [31:0] pz);
		field_sample_t r;
		logic [63:0] s;
		logic [63:0] h;
		longint nint[3], wint[3], nhalf[3], whalf[3];
		longint n[3], w[3];
		longint xy[2][2], xs[2];
		logic [31:0] p[3];
		logic outside;
		logic half;
		logic signed [31:0] res[3];
		p[0] = px; p[1] = py; p[2] = pz;
		outside = 1'b0;
		for (int a = 0; a < 3; a++) begin
			s = ({32'd0, p[a]} * {32'd0, inv_cell[a]}) >> 16;
			h = s + 64'h8000;
			nint[a] = longint'(s >> 16) + 1;
			wint[a] = longint'(s & 64'hffff);
			nhalf[a] = longint'(h >> 16);
			whalf[a] = longint'(h & 64'hffff);
			if ((s >> 16) + 2 >= GRID)
				outside = 1'b1;
		end
		r = '0;
		if (outside) begin
			r.oog = 1'b1;
			return r;
		end
		for (int c = 0; c < 3; c++) begin
			for (int a = 0; a < 3; a++) begin
				half = (f == 0) ? (a == c) : (a != c);
				n[a] = half ? nhalf[a] : nint[a];
				w[a] = half ? whalf[a] : wint[a];
			end
			for (int dx = 0; dx < 2; dx++)
				for (int dy = 0; dy < 2; dy++)
					xy[dx][dy] = blend(
						node_read(f, c, n[0] + dx, n[1] + dy, n[2]),
						node_read(f, c, n[0] + dx, n[1] + dy, n[2] + 1), w[2]);
			for (int dx = 0; dx < 2; dx++)
				xs[dx] = blend(xy[dx][0], xy[dx][1], w[1]);
			res[c] = clamp32(blend(xs[0], xs[1], w[0]));
		end
		r.fx = res[0]; r.fy = res[1]; r.fz = res[2];
		return r;
	endfunction

	task automatic idle_sender();
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_request(logic [1:0] m, logic [31:0] px, logic [31:0] py,
			logic [31:0] pz, logic [4:0] nx, logic [4:0] ny, logic [4:0] nz,
			logic [1:0] comp, logic fld, logic [31:0] val);
		in_valid    <= 1'b1;
		mode        <= m;
		pos_x       <= px;
		pos_y       <= py;
		pos_z       <= pz;
		node_x      <= nx;
		node_y      <= ny;
		node_z      <= nz;
		component   <= comp;
		which_field <= fld;
		node_value  <= val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (m == MODE_WRITE) begin
			if (comp != COMP_NONE)
				node_mem[node_addr(fld, comp, nx, ny, nz)] = val;
		end else if (m != MODE_NONE) begin
			pending_fields = {pending_fields, gather_field(m == MODE_B, px, py, pz)};
		end
		idle_sender();
	endtask

	task automatic write_node(int f, int c, int x, int y, int z, logic [31:0] val);
		send_request(MODE_WRITE, $urandom, $urandom, $urandom, x, y, z, c, f, val);
	endtask

	task automatic query(logic [1:0] m, logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		send_request(m, px, py, pz, $urandom, $urandom, $urandom, $urandom_range(0, 3),
			$urandom, $urandom);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_fields.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		inv_cell[idx] = val;
		@(posedge clk);
	endtask

	task automatic set_scale(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
		wait_idle();
		write_reg(CFG_INV_X, sx);
		write_reg(CFG_INV_Y, sy);
		write_reg(CFG_INV_Z, sz);
	endtask

	task automatic test_directed();
		for (int f = 0; f < 2; f++)
			for (int c = 0; c < 3; c++) begin
				write_node(f, c, 1, 1, 1, 32'h7fffffff);
				write_node(f, c, 2, 1, 1, 32'h80000000);
			end
		write_node(1, 2, 31, 31, 31, 32'h0001_0000);
		send_request(MODE_WRITE, 0, 0, 0, 1, 1, 1, COMP_NONE, 0, 32'h1234_5678);
		send_request(MODE_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		query(MODE_E, 0, 0, 0);
		query(MODE_B, 0, 0, 0);
		query(MODE_E, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
		query(MODE_B, 32'h0000_c000, 32'h0000_4000, 32'h0000_ffff);
		query(MODE_E, 32'h001d_ffff, 32'h001d_ffff, 32'h001d_ffff);
		query(MODE_B, 32'h001e_0000, 0, 0);
		query(MODE_E, 0, 0, 32'h001e_0000);
		query(MODE_B, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
	endtask

	task automatic test_random(int count);
		logic [31:0] p[3];
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 19))
				0: send_request(MODE_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom);
				1, 2, 3, 4, 5, 6, 7, 8:
					send_request(MODE_WRITE, $urandom, $urandom, $urandom,
						($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6),
						($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6),
						($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6),
						($urandom_range(0, 19) == 0) ? COMP_NONE : $urandom_range(0, 2),
						$urandom, $urandom);
				default: begin
					for (int a = 0; a < 3; a++)
						p[a] = ($urandom_range(0, 9) == 0) ? $urandom
							: $urandom_range(0, 32'h0005_0000);
					query($urandom_range(0, 1) ? MODE_E : MODE_B, p[0], p[1], p[2]);
				end
			endcase
		end
	endtask

	always @(posedge clk) begin
		field_sample_t exp_f;
		if (out_valid && out_ready) begin
			if (pending_fields.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h %h %h oog=%b",
						field_x, field_y, field_z, out_of_grid);
			end else begin
				exp_f = pending_fields.pop_front();
				if (exp_f.fx !== field_x || exp_f.fy !== field_y || exp_f.fz !== field_z
						|| exp_f.oog !== out_of_grid) begin
					mismatches++;
					if (mismatches <= 10)
						$display("field mismatch exp %h %h %h oog=%b got %h %h %h oog=%b",
							exp_f.fx, exp_f.fy, exp_f.fz, exp_f.oog,
							field_x, field_y, field_z, out_of_grid);
				end
			end
		end
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		mode        = MODE_WRITE;
		pos_x       = '0;
		pos_y       = '0;
		pos_z       = '0;
		node_x      = '0;
		node_y      = '0;
		node_z      = '0;
		component   = '0;
		which_field = 1'b0;
		node_value  = '0;
		out_ready   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_INV_X;
		cfg_data    = '0;
		mismatches  = 0;
		send_idle_pct  = 10;
		recv_stall_pct = 67;
		for (int i = 0; i < STORE_DEPTH; i++)
			node_mem[i] = '0;
		for (int a = 0; a < 3; a++)
			inv_cell[a] = 32'h0001_0000;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random(300);
		set_scale(32'h0000_8000, 32'h0002_0000, 32'h0001_8000);
		send_idle_pct  = 67;
		recv_stall_pct = 10;
		test_random(300);
		set_scale(32'hffff_ffff, 32'h0000_0000, 32'h0001_0000);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_directed();
		test_random(80);
		set_scale($urandom_range(32'h4000, 32'h3_0000), $urandom_range(32'h4000, 32'h3_0000),
			$urandom_range(32'h4000, 32'h3_0000));
		test_random(400);
		wait_idle();

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire

@@ yee_grid_field_interpolator_top.f @@
+incdir+sv
sv/yee_gfi_pkg.sv
sv/yee_gfi_dp.sv
sv/yee_gfi_ctrl.sv
sv/yee_grid_field_interpolator_top.sv
tb/tb_top.sv
